[hw/rtl/z80alu_pkg.sv]
package z80alu_pkg;

  // Operation codes; 30 and 31 are unused and pass accumulator, flags and wide input through
  typedef enum logic [4:0] {
    OP_ADD   = 5'd0,
    OP_ADC   = 5'd1,
    OP_SUB   = 5'd2,
    OP_SBC   = 5'd3,
    OP_AND   = 5'd4,
    OP_XOR   = 5'd5,
    OP_OR    = 5'd6,
    OP_CP    = 5'd7,
    OP_INC   = 5'd8,
    OP_DEC   = 5'd9,
    OP_ADD16 = 5'd10,
    OP_ADC16 = 5'd11,
    OP_SBC16 = 5'd12,
    OP_RLCA  = 5'd13,
    OP_RRCA  = 5'd14,
    OP_RLA   = 5'd15,
    OP_RRA   = 5'd16,
    OP_DAA   = 5'd17,
    OP_CPL   = 5'd18,
    OP_SCF   = 5'd19,
    OP_CCF   = 5'd20,
    OP_RLC   = 5'd21,
    OP_RRC   = 5'd22,
    OP_RL    = 5'd23,
    OP_RR    = 5'd24,
    OP_SLA   = 5'd25,
    OP_SRA   = 5'd26,
    OP_SLL   = 5'd27,
    OP_SRL   = 5'd28,
    OP_BIT   = 5'd29
  } op_t;

  // Flag bit positions
  localparam int unsigned FLAG_S  = 7;
  localparam int unsigned FLAG_Z  = 6;
  localparam int unsigned FLAG_5  = 5;
  localparam int unsigned FLAG_H  = 4;
  localparam int unsigned FLAG_3  = 3;
  localparam int unsigned FLAG_PV = 2;
  localparam int unsigned FLAG_N  = 1;
  localparam int unsigned FLAG_C  = 0;

  // DAA constants
  localparam logic [7:0] DAA_LO_CORR = 8'h06;
  localparam logic [7:0] DAA_HI_CORR = 8'h60;
  localparam logic [7:0] DAA_HI_LIM  = 8'h99;
  localparam logic [3:0] DAA_LO_LIM  = 4'd9;

  // Captured input item
  typedef struct packed {
    op_t         op;
    logic [7:0]  a;
    logic [7:0]  f;
    logic [15:0] v16;
    logic [15:0] w;
    logic [2:0]  b;
  } in_t;

  // Intermediate results between execute and flag stages
  typedef struct packed {
    op_t         op;
    logic [7:0]  a;
    logic [7:0]  f;
    logic [15:0] v16;
    logic [15:0] w;
    logic [7:0]  r8;
    logic        cy;
    logic [15:0] r16;
    logic        c16;
    logic        daa_h;
    logic        bit_zero;
    logic        bit_sign;
    logic [15:0] wz;
  } mid_t;

endpackage

[hw/rtl/z80alu_exec.sv]
module z80alu_exec (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  z80alu_pkg::in_t   in_item,
  output logic              mid_valid,
  output z80alu_pkg::mid_t  mid
);

  z80alu_pkg::mid_t mid_next;

  logic [7:0]  a;
  logic [7:0]  f;
  logic [7:0]  v;
  logic        c;
  logic        cin;
  logic [8:0]  add9;
  logic [8:0]  sub9;
  logic [16:0] add17;
  logic [16:0] sub17;
  logic        daa_lo;
  logic        daa_hi;
  logic [7:0]  daa_corr;

  assign a = in_item.a;
  assign f = in_item.f;
  assign v = in_item.v16[7:0];
  assign c = f[z80alu_pkg::FLAG_C];
  assign cin = ((in_item.op == z80alu_pkg::OP_ADC) || (in_item.op == z80alu_pkg::OP_SBC)) ?
               c : 1'b0;

  // 8-bit and 16-bit adders; bit 8 / bit 16 is carry or borrow
  assign add9  = {1'b0, a} + {1'b0, v} + {8'b0, cin};
  assign sub9  = {1'b0, a} - {1'b0, v} - {8'b0, cin};
  assign add17 = {1'b0, in_item.w} + {1'b0, in_item.v16} +
                 {16'b0, (in_item.op == z80alu_pkg::OP_ADC16) ? c : 1'b0};
  assign sub17 = {1'b0, in_item.w} - {1'b0, in_item.v16} - {16'b0, c};

  // Decimal adjust correction
  assign daa_lo   = f[z80alu_pkg::FLAG_H] || (a[3:0] > z80alu_pkg::DAA_LO_LIM);
  assign daa_hi   = c || (a > z80alu_pkg::DAA_HI_LIM);
  assign daa_corr = (daa_lo ? z80alu_pkg::DAA_LO_CORR : 8'h00) |
                    (daa_hi ? z80alu_pkg::DAA_HI_CORR : 8'h00);

  // Result byte, carry and 16-bit result per operation
  always_comb begin
    mid_next          = '0;
    mid_next.op       = in_item.op;
    mid_next.a        = a;
    mid_next.f        = f;
    mid_next.v16      = in_item.v16;
    mid_next.w        = in_item.w;
    mid_next.r8       = a;
    mid_next.cy       = c;
    mid_next.r16      = in_item.w;
    mid_next.c16      = 1'b0;
    mid_next.daa_h    = 1'b0;
    mid_next.bit_zero = ~v[in_item.b];
    mid_next.bit_sign = (in_item.b == 3'd7) && v[7];
    mid_next.wz       = in_item.w + 16'd1;
    case (in_item.op)
      z80alu_pkg::OP_ADD, z80alu_pkg::OP_ADC: begin
        mid_next.r8 = add9[7:0];
        mid_next.cy = add9[8];
      end
      z80alu_pkg::OP_SUB, z80alu_pkg::OP_SBC, z80alu_pkg::OP_CP: begin
        mid_next.r8 = sub9[7:0];
        mid_next.cy = sub9[8];
      end
      z80alu_pkg::OP_AND: mid_next.r8 = a & v;
      z80alu_pkg::OP_XOR: mid_next.r8 = a ^ v;
      z80alu_pkg::OP_OR:  mid_next.r8 = a | v;
      z80alu_pkg::OP_INC: mid_next.r8 = v + 8'd1;
      z80alu_pkg::OP_DEC: mid_next.r8 = v - 8'd1;
      z80alu_pkg::OP_ADD16, z80alu_pkg::OP_ADC16: begin
        mid_next.r16 = add17[15:0];
        mid_next.c16 = add17[16];
      end
      z80alu_pkg::OP_SBC16: begin
        mid_next.r16 = sub17[15:0];
        mid_next.c16 = sub17[16];
      end
      z80alu_pkg::OP_RLCA: begin
        mid_next.r8 = {a[6:0], a[7]};
        mid_next.cy = a[7];
      end
      z80alu_pkg::OP_RRCA: begin
        mid_next.r8 = {a[0], a[7:1]};
        mid_next.cy = a[0];
      end
      z80alu_pkg::OP_RLA: begin
        mid_next.r8 = {a[6:0], c};
        mid_next.cy = a[7];
      end
      z80alu_pkg::OP_RRA: begin
        mid_next.r8 = {c, a[7:1]};
        mid_next.cy = a[0];
      end
      z80alu_pkg::OP_DAA: begin
        mid_next.cy = daa_hi;
        if (f[z80alu_pkg::FLAG_N]) begin
          mid_next.r8    = a - daa_corr;
          mid_next.daa_h = a[3:0] < daa_corr[3:0];
        end else begin
          mid_next.r8    = a + daa_corr;
          mid_next.daa_h = ({1'b0, a[3:0]} + {1'b0, daa_corr[3:0]}) > 5'd15;
        end
      end
      z80alu_pkg::OP_CPL: mid_next.r8 = ~a;
      z80alu_pkg::OP_RLC: begin
        mid_next.r8 = {v[6:0], v[7]};
        mid_next.cy = v[7];
      end
      z80alu_pkg::OP_RRC: begin
        mid_next.r8 = {v[0], v[7:1]};
        mid_next.cy = v[0];
      end
      z80alu_pkg::OP_RL: begin
        mid_next.r8 = {v[6:0], c};
        mid_next.cy = v[7];
      end
      z80alu_pkg::OP_RR: begin
        mid_next.r8 = {c, v[7:1]};
        mid_next.cy = v[0];
      end
      z80alu_pkg::OP_SLA: begin
        mid_next.r8 = {v[6:0], 1'b0};
        mid_next.cy = v[7];
      end
      z80alu_pkg::OP_SRA: begin
        mid_next.r8 = {v[7], v[7:1]};
        mid_next.cy = v[0];
      end
      z80alu_pkg::OP_SLL: begin
        mid_next.r8 = {v[6:0], 1'b1};
        mid_next.cy = v[7];
      end
      z80alu_pkg::OP_SRL: begin
        mid_next.r8 = {1'b0, v[7:1]};
        mid_next.cy = v[0];
      end
      default: ;
    endcase
  end

  // Stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else begin
      mid_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      mid <= mid_next;
    end
  end

endmodule

[hw/rtl/z80_alu_with_flags.sv]
// Channel  | Ports                                              | Transfer
// ---------+----------------------------------------------------+------------------------
// command  | operation acc_in flags_in operand wide_in bit_index | start high, busy low
// result   | acc_out flags_out result8 result16 wz_out          | done high for one cycle
//
// Three register stages: input capture, execute (adders, shifts, DAA), flag
// assembly with output select. done follows an accepted start through in_valid and mid_valid.
// One operation is accepted every cycle; busy is never raised.
// Synchronous reset clears the valid bits only; the result side cannot stall.
module z80_alu_with_flags (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [4:0]  operation,
  input  logic [7:0]  acc_in,
  input  logic [7:0]  flags_in,
  input  logic [15:0] operand,
  input  logic [15:0] wide_in,
  input  logic [2:0]  bit_index,
  output logic        done,
  output logic [7:0]  acc_out,
  output logic [7:0]  flags_out,
  output logic [7:0]  result8,
  output logic [15:0] result16,
  output logic [15:0] wz_out
);

  logic              in_valid;
  z80alu_pkg::in_t   in_item;
  logic              mid_valid;
  z80alu_pkg::mid_t  mid;

  logic [7:0]  acc_next;
  logic [7:0]  flags_next;
  logic [7:0]  result8_next;
  logic [15:0] result16_next;
  logic [7:0]  szp;
  logic [7:0]  v;
  logic [7:0]  af;
  logic        h8;
  logic        ov_add8;
  logic        ov_sub8;
  logic        h16;
  logic        ov_add16;
  logic        ov_sub16;

  assign busy = 1'b0;

  // Input capture
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_item.op  <= z80alu_pkg::op_t'(operation);
      in_item.a   <= acc_in;
      in_item.f   <= flags_in;
      in_item.v16 <= operand;
      in_item.w   <= wide_in;
      in_item.b   <= bit_index;
    end
  end

  z80alu_exec u_exec (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .mid_valid (mid_valid),
    .mid       (mid)
  );

  // Flag terms from the execute results
  assign v        = mid.v16[7:0];
  assign af       = mid.a | mid.f;
  assign szp      = {mid.r8[7], mid.r8 == 8'h00, mid.r8[5], 1'b0, mid.r8[3], ~^mid.r8,
                     2'b00};
  assign h8       = mid.a[4] ^ v[4] ^ mid.r8[4];
  assign ov_add8  = ~(mid.a[7] ^ v[7]) & (mid.a[7] ^ mid.r8[7]);
  assign ov_sub8  = (mid.a[7] ^ v[7]) & (mid.a[7] ^ mid.r8[7]);
  assign h16      = mid.w[12] ^ mid.v16[12] ^ mid.r16[12];
  assign ov_add16 = ~(mid.w[15] ^ mid.v16[15]) & (mid.w[15] ^ mid.r16[15]);
  assign ov_sub16 = (mid.w[15] ^ mid.v16[15]) & (mid.w[15] ^ mid.r16[15]);

  // Flag assembly and output select
  always_comb begin
    acc_next      = mid.a;
    flags_next    = mid.f;
    result8_next  = 8'h00;
    result16_next = mid.w;
    case (mid.op)
      z80alu_pkg::OP_ADD, z80alu_pkg::OP_ADC: begin
        acc_next   = mid.r8;
        flags_next = {mid.r8[7], mid.r8 == 8'h00, mid.r8[5], h8, mid.r8[3], ov_add8,
                      1'b0, mid.cy};
      end
      z80alu_pkg::OP_SUB, z80alu_pkg::OP_SBC: begin
        acc_next   = mid.r8;
        flags_next = {mid.r8[7], mid.r8 == 8'h00, mid.r8[5], h8, mid.r8[3], ov_sub8,
                      1'b1, mid.cy};
      end
      z80alu_pkg::OP_CP: begin
        flags_next = {mid.r8[7], mid.r8 == 8'h00, v[5], h8, v[3], ov_sub8, 1'b1, mid.cy};
      end
      z80alu_pkg::OP_AND: begin
        acc_next   = mid.r8;
        flags_next = szp | 8'h10;
      end
      z80alu_pkg::OP_XOR, z80alu_pkg::OP_OR: begin
        acc_next   = mid.r8;
        flags_next = szp;
      end
      z80alu_pkg::OP_INC: begin
        flags_next = {mid.r8[7], mid.r8 == 8'h00, mid.r8[5], v[3:0] == 4'hF, mid.r8[3],
                      v == 8'h7F, 1'b0, mid.f[z80alu_pkg::FLAG_C]};
      end
      z80alu_pkg::OP_DEC: begin
        flags_next = {mid.r8[7], mid.r8 == 8'h00, mid.r8[5], v[3:0] == 4'h0, mid.r8[3],
                      v == 8'h80, 1'b1, mid.f[z80alu_pkg::FLAG_C]};
      end
      z80alu_pkg::OP_ADD16: begin
        result16_next = mid.r16;
        flags_next    = {mid.f[7:6], mid.r16[13], h16, mid.r16[11],
                         mid.f[z80alu_pkg::FLAG_PV], 1'b0, mid.c16};
      end
      z80alu_pkg::OP_ADC16: begin
        result16_next = mid.r16;
        flags_next    = {mid.r16[15], mid.r16 == 16'h0000, mid.r16[13], h16, mid.r16[11],
                         ov_add16, 1'b0, mid.c16};
      end
      z80alu_pkg::OP_SBC16: begin
        result16_next = mid.r16;
        flags_next    = {mid.r16[15], mid.r16 == 16'h0000, mid.r16[13], h16, mid.r16[11],
                         ov_sub16, 1'b1, mid.c16};
      end
      z80alu_pkg::OP_RLCA, z80alu_pkg::OP_RRCA, z80alu_pkg::OP_RLA, z80alu_pkg::OP_RRA: begin
        acc_next   = mid.r8;
        flags_next = {mid.f[7:6], mid.r8[5], 1'b0, mid.r8[3], mid.f[z80alu_pkg::FLAG_PV],
                      1'b0, mid.cy};
      end
      z80alu_pkg::OP_DAA: begin
        acc_next   = mid.r8;
        flags_next = {szp[7:5], mid.daa_h, szp[3:2], mid.f[z80alu_pkg::FLAG_N], mid.cy};
      end
      z80alu_pkg::OP_CPL: begin
        acc_next   = mid.r8;
        flags_next = {mid.f[7:6], mid.r8[5], 1'b1, mid.r8[3], mid.f[z80alu_pkg::FLAG_PV],
                      1'b1, mid.f[z80alu_pkg::FLAG_C]};
      end
      z80alu_pkg::OP_SCF: begin
        flags_next = {mid.f[7:6], af[5], 1'b0, af[3], mid.f[z80alu_pkg::FLAG_PV], 1'b0, 1'b1};
      end
      z80alu_pkg::OP_CCF: begin
        flags_next = {mid.f[7:6], af[5], mid.f[z80alu_pkg::FLAG_C], af[3],
                      mid.f[z80alu_pkg::FLAG_PV], 1'b0, ~mid.f[z80alu_pkg::FLAG_C]};
      end
      z80alu_pkg::OP_RLC, z80alu_pkg::OP_RRC, z80alu_pkg::OP_RL, z80alu_pkg::OP_RR,
      z80alu_pkg::OP_SLA, z80alu_pkg::OP_SRA, z80alu_pkg::OP_SLL, z80alu_pkg::OP_SRL: begin
        flags_next = {szp[7:1], mid.cy};
      end
      z80alu_pkg::OP_BIT: begin
        flags_next = {mid.bit_sign, mid.bit_zero, v[5], 1'b1, v[3], mid.bit_zero, 1'b0,
                      mid.f[z80alu_pkg::FLAG_C]};
      end
      default: ;
    endcase
    // Result byte: shifted or stepped byte where the operation makes one
    case (mid.op)
      z80alu_pkg::OP_INC, z80alu_pkg::OP_DEC,
      z80alu_pkg::OP_RLC, z80alu_pkg::OP_RRC, z80alu_pkg::OP_RL, z80alu_pkg::OP_RR,
      z80alu_pkg::OP_SLA, z80alu_pkg::OP_SRA, z80alu_pkg::OP_SLL, z80alu_pkg::OP_SRL:
        result8_next = mid.r8;
      default:
        result8_next = acc_next;
    endcase
  end

  // Output registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_valid) begin
      acc_out   <= acc_next;
      flags_out <= flags_next;
      result8   <= result8_next;
      result16  <= result16_next;
      wz_out    <= mid.wz;
    end
  end

endmodule
